// ----- rtl/q96_sqrt_price_from_ratio_unit_assert.svh -----
// Assertion macros shared by the Q64.96 square-root price unit
`ifndef Q96_SQRT_PRICE_FROM_RATIO_UNIT_ASSERT_SVH
`define Q96_SQRT_PRICE_FROM_RATIO_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset
`define Q96SP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("q96sp: property violated");
// Condition in one cycle implies an outcome in the next
`define Q96SP_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("q96sp: next-cycle property violated");
`else
`define Q96SP_ASSERT(label, clk, rst_n, prop)
`define Q96SP_ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

// ----- rtl/q96sp_pkg.sv -----
// Types and constants of the Q64.96 square-root price unit
package q96sp_pkg;

    localparam int AMT_W       = 256;          // amount width
    localparam int QUO_W       = 320;          // widest accepted quotient
    localparam int ROOT_W      = 160;          // Q64.96 price width
    localparam int OPND_W      = AMT_W + 1;    // shared subtractor width
    localparam int DIV_CYCLES  = 448;          // numerator bits (amount1 << 192)
    localparam int SQRT_CYCLES = ROOT_W;       // one root bit per cycle
    localparam int CNT_W       = $clog2(DIV_CYCLES);
    localparam int STATUS_W    = 3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_AMT1_ZERO = 3'd1;
    localparam logic [STATUS_W-1:0] ST_AMT0_ZERO = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

    // Sequencer strobes to the datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic finish;
    } t_ctrl;

    // One finished result
    typedef struct packed {
        logic [ROOT_W-1:0]   price;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage

// ----- rtl/q96sp_if.sv -----
// Valid/ready channel interfaces for the amounts and the price result
interface q96sp_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] amount1_w0;
    logic [63:0] amount1_w1;
    logic [63:0] amount1_w2;
    logic [63:0] amount1_w3;
    logic [63:0] amount0_w0;
    logic [63:0] amount0_w1;
    logic [63:0] amount0_w2;
    logic [63:0] amount0_w3;

    modport source (
        output valid, amount1_w0, amount1_w1, amount1_w2, amount1_w3,
               amount0_w0, amount0_w1, amount0_w2, amount0_w3,
        input  ready
    );
    modport sink (
        input  valid, amount1_w0, amount1_w1, amount1_w2, amount1_w3,
               amount0_w0, amount0_w1, amount0_w2, amount0_w3,
        output ready
    );
endinterface

interface q96sp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] price_w0;
    logic [63:0] price_w1;
    logic [31:0] price_w2;
    logic [2:0]  status;

    modport source (
        output valid, price_w0, price_w1, price_w2, status,
        input  ready
    );
    modport sink (
        input  valid, price_w0, price_w1, price_w2, status,
        output ready
    );
endinterface

// ----- rtl/q96sp_sub.sv -----
// Shared 257-bit subtract and compare unit
module q96sp_sub
    import q96sp_pkg::*;
(
    input  logic [OPND_W-1:0] i_a,
    input  logic [OPND_W-1:0] i_b,
    output logic [OPND_W-1:0] o_diff,
    output logic              o_ge
);

    logic borrow;

    // One wide subtract; no borrow means a >= b
    assign {borrow, o_diff} = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge = ~borrow;

endmodule

// ----- rtl/q96sp_seq.sv -----
// Sequencer: division pass, root pass and result hand-off
`include "q96_sqrt_price_from_ratio_unit_assert.svh"
module q96sp_seq
    import q96sp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    output logic  o_in_ready,
    output t_ctrl o_ctrl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Next state and strobes
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_ctrl     = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_DIV;
                    n_cnt       = CNT_W'(DIV_CYCLES - 1);
                end
            end
            S_DIV: begin
                o_ctrl.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_PREP;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_PREP: begin
                o_ctrl.sqrt_init = 1'b1;
                n_state          = S_SQRT;
                n_cnt            = CNT_W'(SQRT_CYCLES - 1);
            end
            S_SQRT: begin
                o_ctrl.sqrt_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_ctrl.finish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `Q96SP_ASSERT_NEXT(a_div_count, i_clk, i_rst_n, r_state == S_DIV && r_cnt != '0, r_cnt == $past(r_cnt) - 1'b1)
    `Q96SP_ASSERT_NEXT(a_div_to_root, i_clk, i_rst_n, r_state == S_DIV && r_cnt == '0, r_state == S_PREP)
    `Q96SP_ASSERT_NEXT(a_finish_idle, i_clk, i_rst_n, o_ctrl.finish, r_state == S_IDLE && o_in_ready)

endmodule

// ----- rtl/q96sp_core.sv -----
// Datapath: restoring division and digit-by-digit root over one subtractor
module q96sp_core
    import q96sp_pkg::*;
(
    input  logic             i_clk,
    input  t_ctrl            i_ctrl,
    input  logic [AMT_W-1:0] i_amount1,
    input  logic [AMT_W-1:0] i_amount0,
    output t_result          o_result
);

    logic [AMT_W-1:0]  r_num;   // numerator bits, MSB first
    logic [AMT_W-1:0]  r_den;
    logic [AMT_W-1:0]  r_rem;   // division remainder, then root remainder
    logic [QUO_W-1:0]  r_quo;   // low quotient bits, then root source
    logic [ROOT_W-1:0] r_root;
    logic              r_ovf;   // quotient bit lost above bit 319
    logic              r_nz;    // some quotient bit set
    logic              r_z1;
    logic              r_z0;

    logic [OPND_W-1:0] opnd_a;
    logic [OPND_W-1:0] opnd_b;
    logic [OPND_W-1:0] diff;
    logic              ge;
    logic [AMT_W-1:0]  rem_next;

    // Operand select: root trial is (root << 2) | 1 against two new bits
    always_comb begin
        if (i_ctrl.sqrt_step) begin
            opnd_a = {r_rem[AMT_W-2:0], r_quo[QUO_W-1 -: 2]};
            opnd_b = {(OPND_W - ROOT_W - 2)'(0), r_root, 2'b01};
        end else begin
            opnd_a = {r_rem, r_num[AMT_W-1]};
            opnd_b = {1'b0, r_den};
        end
    end

    q96sp_sub u_sub (
        .i_a    (opnd_a),
        .i_b    (opnd_b),
        .o_diff (diff),
        .o_ge   (ge)
    );

    // Restore on a failed trial
    assign rem_next = ge ? diff[AMT_W-1:0] : opnd_a[AMT_W-1:0];

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_num <= i_amount1;
            r_den <= i_amount0;
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
            r_nz  <= 1'b0;
            r_z1  <= (i_amount1 == '0);
            r_z0  <= (i_amount0 == '0);
        end else if (i_ctrl.div_step) begin
            r_num <= {r_num[AMT_W-2:0], 1'b0};
            r_rem <= rem_next;
            r_quo <= {r_quo[QUO_W-2:0], ge};
            r_ovf <= r_ovf | r_quo[QUO_W-1];
            r_nz  <= r_nz | ge;
        end else if (i_ctrl.sqrt_init) begin
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_ctrl.sqrt_step) begin
            r_rem  <= rem_next;
            r_quo  <= {r_quo[QUO_W-3:0], 2'b00};
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    // Status priority: amount1 zero, amount0 zero, underflow, overflow
    always_comb begin
        o_result.price  = '0;
        o_result.status = ST_OK;
        priority if (r_z1) begin
            o_result.status = ST_AMT1_ZERO;
        end else if (r_z0) begin
            o_result.status = ST_AMT0_ZERO;
        end else if (!r_nz) begin
            o_result.status = ST_UNDERFLOW;
        end else if (r_ovf) begin
            o_result.status = ST_OVERFLOW;
        end else begin
            o_result.price = r_root;
        end
    end

endmodule

// ----- rtl/q96_sqrt_price_from_ratio_unit.sv -----
// Top level of the Q64.96 square-root price unit
// Takes amount1 and amount0 (256 bits each) and returns floor(sqrt((amount1 << 192) / amount0))
// as a 160-bit Q64.96 price with a status code. Each transaction runs from acceptance
// through bit-serial restoring division, a set-up step and a digit-by-digit square root,
// all through one 257-bit subtractor, and then loads the output register, where the
// result is offered. Input ready is high only while the unit is idle, which it is again
// in the cycle after the result is loaded, so a new transaction cannot start before the
// previous one has left the datapath. A new transaction may be accepted while the
// previous result still waits in the output register; its own result then waits in the
// last step until that register is free. Zero amounts, a zero quotient and a quotient
// above 320 bits return a non-zero status with a zero price.
`include "q96_sqrt_price_from_ratio_unit_assert.svh"
module q96_sqrt_price_from_ratio_unit
    import q96sp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    q96sp_in_if.sink           i_in,
    q96sp_out_if.source        o_out
);

    t_ctrl   ctrl;
    t_result result;
    t_result r_out;
    logic    r_out_valid;
    logic    in_ready;
    logic    out_free;

    // Output slot is free when empty or being taken this cycle
    assign out_free = !r_out_valid || o_out.ready;

    q96sp_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_out_free (out_free),
        .o_in_ready (in_ready),
        .o_ctrl     (ctrl)
    );

    q96sp_core u_core (
        .i_clk     (i_clk),
        .i_ctrl    (ctrl),
        .i_amount1 ({i_in.amount1_w3, i_in.amount1_w2, i_in.amount1_w1, i_in.amount1_w0}),
        .i_amount0 ({i_in.amount0_w3, i_in.amount0_w2, i_in.amount0_w1, i_in.amount0_w0}),
        .o_result  (result)
    );

    assign i_in.ready = in_ready;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.finish) begin
            r_out <= result;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.price_w0 = r_out.price[63:0];
    assign o_out.price_w1 = r_out.price[127:64];
    assign o_out.price_w2 = r_out.price[ROOT_W-1:128];
    assign o_out.status   = r_out.status;

    `Q96SP_ASSERT(a_err_zero_price, i_clk, i_rst_n, r_out_valid && r_out.status != ST_OK |-> r_out.price == '0)

endmodule
